### design/cbsf_pkg.sv
// Shared types, line codes and the CRC fold for the byte stuffing framer.
`timescale 1ns / 1ps

package cbsf_pkg;

	localparam logic [7:0]  ESC_BYTE   = 8'h17;
	localparam logic [7:0]  STUFF_BYTE = 8'h12;
	localparam logic [7:0]  START_BYTE = 8'h13;
	localparam logic [7:0]  END_BYTE   = 8'h05;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'h1021;

	// One classified payload word, queued between front and back.
	typedef struct packed {
		logic        hdr;   // opens a frame: header goes first
		logic [7:0]  data;
		logic        last;  // closes the frame: CRC and trailer follow
		logic [15:0] crc;   // CRC after folding this byte
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Next line byte to send for the queue head.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HDR_ESC,
		ST_HDR_SOF,
		ST_DATA,
		ST_DATA_STF,
		ST_CRCH,
		ST_CRCH_STF,
		ST_CRCL,
		ST_CRCL_STF,
		ST_TRL_ESC,
		ST_TRL_EOF
	} step_t;

	// CRC-16/CCITT-FALSE, MSB first, one byte.
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### design/cbsf_ifs.sv
// Valid/ready channel interfaces for payload words in and line words out.
`timescale 1ns / 1ps

interface cbsf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cbsf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_end;

	modport source (output valid, output out_byte, output frame_end, input ready);
	modport sink   (input valid, input out_byte, input frame_end, output ready);
endinterface

### design/cbsf_front.sv
// Front end: accepts payload words, tracks frame state and folds the CRC.
`timescale 1ns / 1ps

module cbsf_front (
	input  logic                clk,
	input  logic                arst_n,
	cbsf_in_if.sink             ingress,
	input  cbsf_pkg::q_status_t q_stat,
	output logic                wr_en,
	output cbsf_pkg::entry_t    wr_entry
);

	logic        frame_open_q;
	logic [15:0] crc_q;
	logic [15:0] crc_base;
	logic [15:0] crc_next;

	assign ingress.ready = !q_stat.full;
	assign wr_en         = ingress.valid && !q_stat.full;

	assign crc_base = frame_open_q ? crc_q : cbsf_pkg::CRC_INIT;
	assign crc_next = cbsf_pkg::crc_fold(crc_base, ingress.data_byte);

	always_comb begin
		wr_entry.hdr  = !frame_open_q;
		wr_entry.data = ingress.data_byte;
		wr_entry.last = ingress.last_byte;
		wr_entry.crc  = crc_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			crc_q        <= cbsf_pkg::CRC_INIT;
		end else if (wr_en) begin
			frame_open_q <= !ingress.last_byte;
			crc_q        <= crc_next;
		end
	end

endmodule

### design/cbsf_fifo.sv
// Small queue of classified words between front and back.
`timescale 1ns / 1ps

module cbsf_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  cbsf_pkg::entry_t    wr_entry,
	input  logic                rd_en,
	output cbsf_pkg::entry_t    head,
	output cbsf_pkg::q_status_t q_stat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cbsf_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == CNT_W'(DEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### design/cbsf_back.sv
// Back end: walks the queue head through header, stuffing, CRC and trailer.
`timescale 1ns / 1ps

module cbsf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  cbsf_pkg::q_status_t q_stat,
	input  cbsf_pkg::entry_t    head,
	output logic                rd_en,
	cbsf_out_if.source          egress
);

	cbsf_pkg::step_t step_q;
	cbsf_pkg::step_t step_d;
	cbsf_pkg::step_t cur_step;

	logic       ovalid_q;
	logic [7:0] obyte_q;
	logic       oend_q;

	logic       load;
	logic       emit;
	logic       done;
	logic [7:0] byte_d;

	assign load = !ovalid_q || egress.ready;
	assign emit = load && !q_stat.empty;

	always_comb begin
		cur_step = step_q;
		if (step_q == cbsf_pkg::ST_IDLE) begin
			cur_step = head.hdr ? cbsf_pkg::ST_HDR_ESC : cbsf_pkg::ST_DATA;
		end

		done   = 1'b0;
		step_d = cur_step;
		byte_d = cbsf_pkg::ESC_BYTE;
		unique case (cur_step)
			cbsf_pkg::ST_HDR_ESC: begin
				byte_d = cbsf_pkg::ESC_BYTE;
				step_d = cbsf_pkg::ST_HDR_SOF;
			end
			cbsf_pkg::ST_HDR_SOF: begin
				byte_d = cbsf_pkg::START_BYTE;
				step_d = cbsf_pkg::ST_DATA;
			end
			cbsf_pkg::ST_DATA: begin
				byte_d = head.data;
				if (head.data == cbsf_pkg::ESC_BYTE) begin
					step_d = cbsf_pkg::ST_DATA_STF;
				end else if (head.last) begin
					step_d = cbsf_pkg::ST_CRCH;
				end else begin
					done = 1'b1;
				end
			end
			cbsf_pkg::ST_DATA_STF: begin
				byte_d = cbsf_pkg::STUFF_BYTE;
				if (head.last) begin
					step_d = cbsf_pkg::ST_CRCH;
				end else begin
					done = 1'b1;
				end
			end
			cbsf_pkg::ST_CRCH: begin
				byte_d = head.crc[15:8];
				step_d = (head.crc[15:8] == cbsf_pkg::ESC_BYTE) ?
					cbsf_pkg::ST_CRCH_STF : cbsf_pkg::ST_CRCL;
			end
			cbsf_pkg::ST_CRCH_STF: begin
				byte_d = cbsf_pkg::STUFF_BYTE;
				step_d = cbsf_pkg::ST_CRCL;
			end
			cbsf_pkg::ST_CRCL: begin
				byte_d = head.crc[7:0];
				step_d = (head.crc[7:0] == cbsf_pkg::ESC_BYTE) ?
					cbsf_pkg::ST_CRCL_STF : cbsf_pkg::ST_TRL_ESC;
			end
			cbsf_pkg::ST_CRCL_STF: begin
				byte_d = cbsf_pkg::STUFF_BYTE;
				step_d = cbsf_pkg::ST_TRL_ESC;
			end
			cbsf_pkg::ST_TRL_ESC: begin
				byte_d = cbsf_pkg::ESC_BYTE;
				step_d = cbsf_pkg::ST_TRL_EOF;
			end
			cbsf_pkg::ST_TRL_EOF: begin
				byte_d = cbsf_pkg::END_BYTE;
				done   = 1'b1;
			end
			default: begin
				byte_d = cbsf_pkg::ESC_BYTE;
				step_d = cbsf_pkg::ST_IDLE;
			end
		endcase
		if (done) begin
			step_d = cbsf_pkg::ST_IDLE;
		end
	end

	assign rd_en = emit && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= cbsf_pkg::ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (emit) begin
				step_q <= step_d;
			end
			if (load) begin
				ovalid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			obyte_q <= byte_d;
			oend_q  <= (cur_step == cbsf_pkg::ST_TRL_EOF);
		end
	end

	assign egress.valid     = ovalid_q;
	assign egress.out_byte  = obyte_q;
	assign egress.frame_end = oend_q;

endmodule

### design/crc16_byte_stuffing_framer.sv
// Top level of the CRC-16 byte stuffing framer.
//
// channel  dir  word                   notes
// -------  ---  ---------------------  ----------------------------------------
// ingress  in   data_byte, last_byte   one payload byte; last_byte closes frame
// egress   out  out_byte, frame_end    one line byte; frame_end on trailer 0x05
//
// Line bytes: the line side sends one byte per cycle while egress is ready and
//   a word is queued, so a payload word takes one byte, two if it equals 0x17,
//   plus two for a header and four to six for the CRC and trailer; the back end sequencer sets that rate.
// Reset: arst_n clears frame state, queue and output; the next word opens
//   a new frame (a frame open at reset is dropped without trailer).
// Stalls: the queue lets ingress keep accepting while egress is held, until it is full.
`timescale 1ns / 1ps

module crc16_byte_stuffing_framer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	cbsf_in_if.sink     ingress,
	cbsf_out_if.source  egress
);

	// front end -> queue
	logic                wr_en;
	cbsf_pkg::entry_t    wr_entry;

	// queue -> back end
	logic                rd_en;
	cbsf_pkg::entry_t    head;
	cbsf_pkg::q_status_t q_stat;

	// Classification and CRC folding happen at accept time.
	cbsf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.ingress  (ingress),
		.q_stat   (q_stat),
		.wr_en    (wr_en),
		.wr_entry (wr_entry)
	);

	cbsf_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_entry (wr_entry),
		.rd_en    (rd_en),
		.head     (head),
		.q_stat   (q_stat)
	);

	// Expands each queued word into its line bytes, one per cycle while egress is ready.
	cbsf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.head   (head),
		.rd_en  (rd_en),
		.egress (egress)
	);

endmodule
